FILE: src/arp_pkg.sv
`default_nettype none

package arp_pkg;

	localparam int unsigned IDX_W      = 64;
	localparam int unsigned CAP_W      = 21;
	localparam int unsigned STALE_W    = 40;
	localparam int unsigned REQ_W      = 7;
	localparam int unsigned SLOT_W     = 20;
	localparam int unsigned OFF_W      = 6;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 40;

	localparam int unsigned MAX_REQUEST_DEF = 64;
	localparam int unsigned SLOT_BITS_DEF   = 20;

	localparam logic [CAP_W-1:0]   RING_CAPACITY_RST  = 21'd4096;
	localparam logic [STALE_W-1:0] STALE_LIMIT_RST    = 40'd100000000;
	localparam logic               PUBLISH_ENABLE_RST = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RING_CAPACITY  = 2'd0,
		CFG_STALE_LIMIT    = 2'd1,
		CFG_PUBLISH_ENABLE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_ATTACH = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NOT_MAPPED  = 3'd1,
		ST_INVALID     = 3'd2,
		ST_STALE       = 3'd3,
		ST_GEN_CHANGED = 3'd4,
		ST_OVERRUN     = 3'd5,
		ST_UNDERRUN    = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ATTACH,
		S_HB_DIFF,
		S_STALE_CMP,
		S_AVAIL,
		S_OVR_CMP,
		S_OVR_FIX,
		S_COMMIT,
		S_MOD,
		S_EMIT,
		S_SINGLE
	} state_t;

	typedef struct packed {
		logic             cmd;
		logic             mapped;
		logic             header_valid;
		logic [IDX_W-1:0] write_index;
		logic [IDX_W-1:0] producer_generation;
		logic [IDX_W-1:0] heartbeat_time;
		logic [IDX_W-1:0] now_time;
		logic [REQ_W-1:0] req_frames;
	} in_t;

	typedef struct packed {
		status_t           status;
		logic              frame_present;
		logic              copy_valid;
		logic [SLOT_W-1:0] source_slot;
		logic [OFF_W-1:0]  frame_offset;
		logic              last;
		logic [REQ_W-1:0]  copied_count;
		logic [IDX_W-1:0]  read_index_out;
	} out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_req_t;

	typedef struct packed {
		logic [CAP_W-1:0]   ring_capacity;
		logic [STALE_W-1:0] stale_limit;
		logic               publish_enable;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] sum;
		logic             borrow;
	} alu_rsp_t;

endpackage

`default_nettype wire

FILE: src/arp_ifs.sv
`default_nettype none

interface arp_in_if;
	logic         valid;
	logic         ready;
	arp_pkg::in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface arp_out_if;
	logic          valid;
	logic          ready;
	arp_pkg::out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface arp_cfg_if;
	logic              valid;
	logic              ready;
	arp_pkg::cfg_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/arp_cfg_regs.sv
`default_nettype none

module arp_cfg_regs (
	input  wire logic    clk,
	input  wire logic    arst_n,
	arp_cfg_if.sink      cfg_ch,
	output arp_pkg::cfg_t cfg
);

	arp_pkg::cfg_t cfg_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg          = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ring_capacity  <= arp_pkg::RING_CAPACITY_RST;
			cfg_q.stale_limit    <= arp_pkg::STALE_LIMIT_RST;
			cfg_q.publish_enable <= arp_pkg::PUBLISH_ENABLE_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.data.index)
				arp_pkg::CFG_RING_CAPACITY: begin
					cfg_q.ring_capacity <= cfg_ch.data.value[arp_pkg::CAP_W-1:0];
				end
				arp_pkg::CFG_STALE_LIMIT: begin
					cfg_q.stale_limit <= cfg_ch.data.value[arp_pkg::STALE_W-1:0];
				end
				arp_pkg::CFG_PUBLISH_ENABLE: begin
					cfg_q.publish_enable <= cfg_ch.data.value[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/arp_addsub.sv
`default_nettype none

module arp_addsub (
	input  arp_pkg::alu_req_t alu_req,
	output arp_pkg::alu_rsp_t alu_rsp
);

	logic [arp_pkg::IDX_W:0]   full;
	logic [arp_pkg::IDX_W-1:0] b_eff;

	assign b_eff = alu_req.sub ? ~alu_req.b : alu_req.b;
	assign full  = {1'b0, alu_req.a} + {1'b0, b_eff} + {{arp_pkg::IDX_W{1'b0}}, alu_req.sub};

	// borrow only meaningful for subtraction
	assign alu_rsp.sum    = full[arp_pkg::IDX_W-1:0];
	assign alu_rsp.borrow = alu_req.sub & ~full[arp_pkg::IDX_W];

endmodule

`default_nettype wire

FILE: src/arp_ctrl.sv
`default_nettype none

module arp_ctrl #(
	parameter int unsigned MAX_REQUEST = arp_pkg::MAX_REQUEST_DEF,
	parameter int unsigned SLOT_BITS   = arp_pkg::SLOT_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  arp_pkg::cfg_t     cfg,
	arp_in_if.sink            cmd_ch,
	arp_out_if.source         rsp_ch,
	output arp_pkg::alu_req_t alu_req,
	input  arp_pkg::alu_rsp_t alu_rsp
);

	localparam int unsigned IDX_W = arp_pkg::IDX_W;
	localparam int unsigned CAP_W = arp_pkg::CAP_W;
	localparam int unsigned REQ_W = arp_pkg::REQ_W;
	localparam int unsigned CNT_W = $clog2(IDX_W);
	localparam logic [IDX_W-1:0] CapLimit = IDX_W'(1) << SLOT_BITS;
	localparam logic [REQ_W-1:0] ReqMax   = REQ_W'(MAX_REQUEST);

	arp_pkg::state_t  state_q, state_d;
	arp_pkg::status_t status_q, chk_status;

	logic             mapped_q, hvalid_q, lt_q;
	logic [IDX_W-1:0] wr_q, gen_q, hb_q, now_q;
	logic [REQ_W-1:0] req_q, copied_q, off_q, copied_c, req_in;
	logic [IDX_W-1:0] read_index_q, seen_gen_q, diff_q, avail_q, start_q;
	logic [CAP_W-1:0] rem_q, rem_inc, rem_next;
	logic [CNT_W-1:0] bit_cnt_q;
	logic [CAP_W:0]   mod_shift;

	logic          out_valid_q, load_ok, load_emit, load_single;
	arp_pkg::out_t out_q;

	logic cap_bad, stale, under, emit_last, emit_copy;

	assign load_ok   = !out_valid_q || rsp_ch.ready;
	assign mod_shift = {rem_q, start_q[IDX_W-1]};
	assign rem_inc   = rem_q + CAP_W'(1);
	assign rem_next  = (rem_inc == cfg.ring_capacity) ? '0 : rem_inc;
	assign emit_last = (off_q + REQ_W'(1)) == req_q;
	assign emit_copy = off_q < copied_q;

	assign req_in = (cmd_ch.data.req_frames > ReqMax) ? ReqMax
		: cmd_ch.data.req_frames;

	always_comb begin
		cap_bad = (cfg.ring_capacity == '0) || (IDX_W'(cfg.ring_capacity) > CapLimit);
		stale   = (now_q != '0) && ((hb_q == '0) || lt_q || alu_rsp.borrow);
		if (!mapped_q) begin
			chk_status = arp_pkg::ST_NOT_MAPPED;
		end else if (!hvalid_q || cap_bad) begin
			chk_status = arp_pkg::ST_INVALID;
		end else if (stale) begin
			chk_status = arp_pkg::ST_STALE;
		end else if (gen_q != seen_gen_q) begin
			chk_status = arp_pkg::ST_GEN_CHANGED;
		end else begin
			chk_status = arp_pkg::ST_OK;
		end
		under    = (avail_q[IDX_W-1:REQ_W] == '0) && (avail_q[REQ_W-1:0] < req_q);
		copied_c = under ? avail_q[REQ_W-1:0] : req_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			arp_pkg::S_IDLE: begin
				if (cmd_ch.valid) begin
					if (cmd_ch.data.cmd == arp_pkg::CMD_ATTACH) begin
						state_d = arp_pkg::S_ATTACH;
					end else if (req_in == '0) begin
						state_d = arp_pkg::S_SINGLE;
					end else begin
						state_d = arp_pkg::S_HB_DIFF;
					end
				end
			end
			arp_pkg::S_ATTACH:    state_d = arp_pkg::S_SINGLE;
			arp_pkg::S_HB_DIFF:   state_d = arp_pkg::S_STALE_CMP;
			arp_pkg::S_STALE_CMP: begin
				state_d = (chk_status != arp_pkg::ST_OK) ? arp_pkg::S_EMIT : arp_pkg::S_AVAIL;
			end
			arp_pkg::S_AVAIL:     state_d = arp_pkg::S_OVR_CMP;
			arp_pkg::S_OVR_CMP: begin
				state_d = alu_rsp.borrow ? arp_pkg::S_OVR_FIX : arp_pkg::S_COMMIT;
			end
			arp_pkg::S_OVR_FIX:   state_d = arp_pkg::S_COMMIT;
			arp_pkg::S_COMMIT: begin
				state_d = (copied_c == '0) ? arp_pkg::S_EMIT : arp_pkg::S_MOD;
			end
			arp_pkg::S_MOD: begin
				if (bit_cnt_q == '1) begin
					state_d = arp_pkg::S_EMIT;
				end
			end
			arp_pkg::S_EMIT: begin
				if (load_ok && emit_last) begin
					state_d = arp_pkg::S_IDLE;
				end
			end
			arp_pkg::S_SINGLE: begin
				if (load_ok) begin
					state_d = arp_pkg::S_IDLE;
				end
			end
			default: state_d = arp_pkg::S_IDLE;
		endcase
	end

	// outputs and shared unit operands
	always_comb begin
		cmd_ch.ready = (state_q == arp_pkg::S_IDLE);
		load_emit    = 1'b0;
		load_single  = 1'b0;
		alu_req.a    = wr_q;
		alu_req.b    = IDX_W'(cfg.ring_capacity);
		alu_req.sub  = 1'b1;
		case (state_q)
			arp_pkg::S_ATTACH: begin
				alu_req.a = wr_q;
				alu_req.b = IDX_W'(cfg.ring_capacity);
			end
			arp_pkg::S_HB_DIFF: begin
				alu_req.a = now_q;
				alu_req.b = hb_q;
			end
			arp_pkg::S_STALE_CMP: begin
				alu_req.a = IDX_W'(cfg.stale_limit);
				alu_req.b = diff_q;
			end
			arp_pkg::S_AVAIL: begin
				alu_req.a = wr_q;
				alu_req.b = read_index_q;
			end
			arp_pkg::S_OVR_CMP: begin
				alu_req.a = IDX_W'(cfg.ring_capacity);
				alu_req.b = avail_q;
			end
			arp_pkg::S_OVR_FIX: begin
				alu_req.a = wr_q;
				alu_req.b = IDX_W'(cfg.ring_capacity);
			end
			arp_pkg::S_COMMIT: begin
				alu_req.a   = read_index_q;
				alu_req.b   = IDX_W'(copied_c);
				alu_req.sub = 1'b0;
			end
			arp_pkg::S_MOD: begin
				alu_req.a = IDX_W'(mod_shift);
				alu_req.b = IDX_W'(cfg.ring_capacity);
			end
			arp_pkg::S_EMIT:   load_emit   = load_ok;
			arp_pkg::S_SINGLE: load_single = load_ok;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_index_q <= '0;
			seen_gen_q   <= '0;
		end else begin
			case (state_q)
				arp_pkg::S_ATTACH: begin
					seen_gen_q   <= gen_q;
					read_index_q <= alu_rsp.borrow ? '0 : alu_rsp.sum;
				end
				arp_pkg::S_STALE_CMP: begin
					if (chk_status == arp_pkg::ST_GEN_CHANGED) begin
						seen_gen_q   <= gen_q;
						read_index_q <= wr_q;
					end
				end
				arp_pkg::S_OVR_FIX: read_index_q <= alu_rsp.sum;
				arp_pkg::S_COMMIT:  read_index_q <= alu_rsp.sum;
				default: begin
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			arp_pkg::S_IDLE: begin
				if (cmd_ch.valid) begin
					mapped_q <= cmd_ch.data.mapped;
					hvalid_q <= cmd_ch.data.header_valid;
					wr_q     <= cmd_ch.data.write_index;
					gen_q    <= cmd_ch.data.producer_generation;
					hb_q     <= cmd_ch.data.heartbeat_time;
					now_q    <= cmd_ch.data.now_time;
					req_q    <= req_in;
				end
			end
			arp_pkg::S_HB_DIFF: begin
				diff_q <= alu_rsp.sum;
				lt_q   <= alu_rsp.borrow;
			end
			arp_pkg::S_STALE_CMP: begin
				status_q <= chk_status;
				copied_q <= '0;
				off_q    <= '0;
			end
			arp_pkg::S_AVAIL: avail_q <= alu_rsp.borrow ? '0 : alu_rsp.sum;
			arp_pkg::S_OVR_CMP: begin
				if (alu_rsp.borrow) begin
					status_q <= arp_pkg::ST_OVERRUN;
				end
			end
			arp_pkg::S_OVR_FIX: avail_q <= IDX_W'(cfg.ring_capacity);
			arp_pkg::S_COMMIT: begin
				copied_q  <= copied_c;
				off_q     <= '0;
				start_q   <= read_index_q;
				rem_q     <= '0;
				bit_cnt_q <= '0;
				if (under && status_q == arp_pkg::ST_OK) begin
					status_q <= arp_pkg::ST_UNDERRUN;
				end
			end
			arp_pkg::S_MOD: begin
				rem_q     <= alu_rsp.borrow ? mod_shift[CAP_W-1:0] : alu_rsp.sum[CAP_W-1:0];
				start_q   <= {start_q[IDX_W-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q + CNT_W'(1);
			end
			arp_pkg::S_EMIT: begin
				if (load_ok) begin
					off_q <= off_q + REQ_W'(1);
					if (emit_copy) begin
						rem_q <= rem_next;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_emit || load_single) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_emit || load_single) begin
			out_q.read_index_out <= cfg.publish_enable ? read_index_q : '0;
			if (load_emit) begin
				out_q.status        <= status_q;
				out_q.frame_present <= 1'b1;
				out_q.copy_valid    <= emit_copy;
				out_q.source_slot   <= emit_copy ? rem_q[arp_pkg::SLOT_W-1:0] : '0;
				out_q.frame_offset  <= off_q[arp_pkg::OFF_W-1:0];
				out_q.last          <= emit_last;
				out_q.copied_count  <= copied_q;
			end else begin
				out_q.status        <= arp_pkg::ST_OK;
				out_q.frame_present <= 1'b0;
				out_q.copy_valid    <= 1'b0;
				out_q.source_slot   <= '0;
				out_q.frame_offset  <= '0;
				out_q.last          <= 1'b1;
				out_q.copied_count  <= '0;
			end
		end
	end

	assign rsp_ch.valid = out_valid_q;
	assign rsp_ch.data  = out_q;

endmodule

`default_nettype wire

FILE: src/audio_ring_read_pointer_unit.sv
`default_nettype none
// channel   dir  payload                         handshake
// cmd_ch    in   arp_pkg::in_t  (attach / read)  valid/ready
// rsp_ch    out  arp_pkg::out_t (one per frame)  valid/ready
// cfg_ch    in   arp_pkg::cfg_req_t index/value  valid/ready, always ready
//
// Attach and empty read request: one result with no frame.
// Error read request: status checks, then one result per frame.
// Good read request: checks, then bit-serial slot modulo on the shared 64-bit add/sub
// unit (skipped when nothing is copied), then one result a cycle unless rsp_ch stalls.
// Output register lets a new request in while the last result waits; rsp_ch stalls hold it.
// Asynchronous reset; no clearing pass.

module audio_ring_read_pointer_unit #(
	parameter int unsigned MAX_REQUEST = arp_pkg::MAX_REQUEST_DEF,
	parameter int unsigned SLOT_BITS   = arp_pkg::SLOT_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	arp_in_if.sink    cmd_ch,
	arp_out_if.source rsp_ch,
	arp_cfg_if.sink   cfg_ch
);

	arp_pkg::cfg_t     cfg;
	arp_pkg::alu_req_t alu_req;
	arp_pkg::alu_rsp_t alu_rsp;

	arp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	arp_addsub u_alu (
		.alu_req (alu_req),
		.alu_rsp (alu_rsp)
	);

	arp_ctrl #(
		.MAX_REQUEST (MAX_REQUEST),
		.SLOT_BITS   (SLOT_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd_ch  (cmd_ch),
		.rsp_ch  (rsp_ch),
		.alu_req (alu_req),
		.alu_rsp (alu_rsp)
	);

endmodule

`default_nettype wire

FILE: verif/audio_ring_read_pointer_unit_tb.sv
`timescale 1ns / 100ps

module audio_ring_read_pointer_unit_tb;
	import arp_pkg::*;

	localparam int LIMIT = 4_000_000;

	typedef struct {
		in_t item;
		bit  hold;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	arp_in_if  cmd_if ();
	arp_out_if rsp_if ();
	arp_cfg_if cfg_if ();

	logic     cmd_valid = 1'b0;
	in_t      cmd_item  = '0;
	logic     rsp_ready = 1'b0;
	logic     cfg_valid = 1'b0;
	cfg_req_t cfg_word  = '0;

	assign cmd_if.valid = cmd_valid;
	assign cmd_if.data  = cmd_item;
	assign rsp_if.ready = rsp_ready;
	assign cfg_if.valid = cfg_valid;
	assign cfg_if.data  = cfg_word;

	audio_ring_read_pointer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_if),
		.rsp_ch (rsp_if),
		.cfg_ch (cfg_if)
	);

	// shadow of the block's registers and pointer state
	logic [CAP_W-1:0]   m_cap;
	logic [STALE_W-1:0] m_stale;
	logic               m_pub;
	logic [IDX_W-1:0]   m_rd;
	logic [IDX_W-1:0]   m_gen;

	pend_t req_backlog[$];
	out_t  frame_plan[$];
	pend_t drv_next;
	out_t  want;

	int  gap_left   = 0;
	int  stall_left = 0;
	bit  quiet      = 1'b0;
	int  cycles     = 0;
	int  errors     = 0;
	int  n_items    = 0;
	int  n_results  = 0;
	int  n_settings = 1;
	int  st_count[7];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d frames outstanding", cycles, frame_plan.size());
			$display("FAIL audio_ring_read_pointer_unit");
			$finish;
		end
	end

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(0, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic void plan_frame(status_t st, logic fp, logic cv, logic [SLOT_W-1:0] slot,
			logic [OFF_W-1:0] off, logic lst, logic [REQ_W-1:0] cnt);
		out_t o;
		o.status         = st;
		o.frame_present  = fp;
		o.copy_valid     = cv;
		o.source_slot    = slot;
		o.frame_offset   = off;
		o.last           = lst;
		o.copied_count   = cnt;
		o.read_index_out = m_pub ? m_rd : '0;
		frame_plan.push_back(o);
	endfunction

	function automatic void plan_request(in_t it);
		logic [63:0] cap64;
		logic [63:0] avail;
		logic [63:0] first;
		logic [63:0] pos;
		int          req;
		int          copied;
		status_t     st;
		cap64 = 64'(m_cap);
		if (it.cmd == CMD_ATTACH) begin
			m_gen = it.producer_generation;
			m_rd  = (it.write_index > cap64) ? it.write_index - cap64 : '0;
			plan_frame(ST_OK, 1'b0, 1'b0, '0, '0, 1'b1, '0);
			return;
		end
		req = int'(it.req_frames);
		if (req > int'(MAX_REQUEST_DEF))
			req = int'(MAX_REQUEST_DEF);
		if (req == 0) begin
			plan_frame(ST_OK, 1'b0, 1'b0, '0, '0, 1'b1, '0);
			return;
		end
		st = ST_OK;
		if (!it.mapped) begin
			st = ST_NOT_MAPPED;
		end else if (!it.header_valid || cap64 == 0 || cap64 > (64'd1 << SLOT_BITS_DEF)) begin
			st = ST_INVALID;
		end else if (it.now_time != 0 && (it.heartbeat_time == 0 ||
				it.now_time < it.heartbeat_time ||
				(it.now_time - it.heartbeat_time) > 64'(m_stale))) begin
			st = ST_STALE;
		end else if (it.producer_generation != m_gen) begin
			m_gen = it.producer_generation;
			m_rd  = it.write_index;
			st    = ST_GEN_CHANGED;
		end
		if (st != ST_OK) begin
			for (int i = 0; i < req; i++)
				plan_frame(st, 1'b1, 1'b0, '0, 6'(i), i == req - 1, '0);
			return;
		end
		avail = (it.write_index > m_rd) ? it.write_index - m_rd : '0;
		if (avail > cap64) begin
			m_rd  = it.write_index - cap64;
			avail = cap64;
			st    = ST_OVERRUN;
		end
		copied = req;
		if (avail < 64'(req)) begin
			copied = int'(avail);
			if (st == ST_OK)
				st = ST_UNDERRUN;
		end
		first = m_rd;
		m_rd  = m_rd + 64'(copied);
		for (int i = 0; i < req; i++) begin
			if (i < copied) begin
				pos = (first + 64'(i)) % cap64;
				plan_frame(st, 1'b1, 1'b1, pos[SLOT_W-1:0], 6'(i), i == req - 1, 7'(copied));
			end else begin
				plan_frame(st, 1'b1, 1'b0, '0, 6'(i), i == req - 1, 7'(copied));
			end
		end
	endfunction

	task automatic flag(string what, out_t w, out_t g);
		errors++;
		if (errors <= 10) begin
			$display("%s: exp st=%0d fp=%0d cv=%0d slot=%0d off=%0d last=%0d cnt=%0d ri=%h",
				what, w.status, w.frame_present, w.copy_valid, w.source_slot, w.frame_offset,
				w.last, w.copied_count, w.read_index_out);
			$display("    got st=%0d fp=%0d cv=%0d slot=%0d off=%0d last=%0d cnt=%0d ri=%h",
				g.status, g.frame_present, g.copy_valid, g.source_slot, g.frame_offset,
				g.last, g.copied_count, g.read_index_out);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd_item  <= '0;
			gap_left  = 0;
		end else begin
			if (cmd_valid && cmd_if.ready) begin
				plan_request(cmd_item);
				n_items++;
			end
			if (!cmd_valid || cmd_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (req_backlog.size() != 0 &&
						!(req_backlog[0].hold && frame_plan.size() != 0)) begin
					drv_next = req_backlog.pop_front();
					cmd_item  <= drv_next.item;
					cmd_valid <= 1'b1;
					gap_left  = quiet ? 0 : gap_len();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_if.valid && rsp_ready) begin
				n_results++;
				if (rsp_if.data.status <= ST_UNDERRUN)
					st_count[rsp_if.data.status]++;
				if (frame_plan.size() == 0) begin
					flag("unexpected frame", '0, rsp_if.data);
				end else begin
					want = frame_plan.pop_front();
					if (rsp_if.data !== want)
						flag("frame mismatch", want, rsp_if.data);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					stall_left = gap_len();
			end
		end
	end

	function automatic in_t mk(cmd_t c, logic m, logic h, logic [63:0] w, logic [63:0] g,
			logic [63:0] hb, logic [63:0] nw, logic [6:0] rq);
		in_t it;
		it.cmd                 = c;
		it.mapped              = m;
		it.header_valid        = h;
		it.write_index         = w;
		it.producer_generation = g;
		it.heartbeat_time      = hb;
		it.now_time            = nw;
		it.req_frames          = rq;
		return it;
	endfunction

	task automatic enqueue(in_t it, bit hold);
		pend_t p;
		p.item = it;
		p.hold = hold;
		req_backlog.push_back(p);
	endtask

	task automatic wait_idle();
		while (req_backlog.size() != 0 || cmd_valid || frame_plan.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
		@(posedge clk);
		cfg_valid      <= 1'b1;
		cfg_word.index <= idx;
		cfg_word.value <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_RING_CAPACITY:  m_cap   = v[CAP_W-1:0];
			CFG_STALE_LIMIT:    m_stale = v[STALE_W-1:0];
			CFG_PUBLISH_ENABLE: m_pub   = v[0];
			default: ;
		endcase
	endtask

	task automatic directed();
		logic [63:0] ones;
		ones = '1;
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd10, 64'd0, 64'd0, 64'd0, 7'd5), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd12, 64'd0, 64'd0, 64'd0, 7'd8), 1'b0);
		enqueue(mk(CMD_ATTACH, 1'b0, 1'b0, 64'd100, 64'd7, 64'd0, 64'd0, 7'd3), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd110, 64'd7, 64'd0, 64'd0, 7'd0), 1'b0);
		enqueue(mk(CMD_READ, 1'b0, 1'b1, 64'd110, 64'd7, 64'd0, 64'd0, 7'd3), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b0, 64'd110, 64'd7, 64'd0, 64'd0, 7'd2), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd110, 64'd7, 64'd0, 64'd5000, 7'd1), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd110, 64'd7, 64'd6000, 64'd5000, 7'd1), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd110, 64'd7, 64'd1, 64'd200000000, 7'd1), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd120, 64'd7, 64'd1, 64'd100000001, 7'd10), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd130, 64'd9, 64'd0, 64'd0, 7'd4), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd10130, 64'd9, 64'd0, 64'd0, 7'd20), 1'b1);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd10500, 64'd9, 64'd0, 64'd0, 7'd127), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd10600, 64'd9, 64'd0, 64'd0, 7'd65), 1'b0);
		enqueue(mk(CMD_ATTACH, 1'b1, 1'b1, ones, ones, ones, ones, 7'd127), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, ones, ones, ones - 64'd5, ones, 7'd64), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, ones, ones, ones, 64'd0, 7'd64), 1'b0);
		enqueue(mk(CMD_ATTACH, 1'b1, 1'b1, 64'd3, 64'd0, 64'd0, 64'd0, 7'd0), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd3, 64'd0, 64'd0, 64'd0, 7'd64), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd3, 64'd0, 64'd0, 64'd0, 7'd5), 1'b0);
		enqueue(mk(CMD_READ, 1'b0, 1'b0, 64'd900, 64'd44, 64'd0, 64'd0, 7'd2), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b0, 64'd900, 64'd44, 64'd0, 64'd0, 7'd2), 1'b0);
		enqueue(mk(CMD_READ, 1'b1, 1'b1, 64'd900, 64'd44, 64'd0, 64'd7, 7'd2), 1'b0);
	endtask

	task automatic gen_phase(int n, logic [CAP_W-1:0] cap, logic [STALE_W-1:0] stl);
		in_t         it;
		logic [63:0] wr;
		logic [63:0] gen;
		logic [63:0] now;
		logic [63:0] delta;
		int          r;
		int          q;
		int          step_max;
		int          dmax;
		wr       = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 5000));
		gen      = ($urandom_range(0, 1) == 0) ? rand64() : 64'($urandom_range(0, 20));
		now      = ($urandom_range(0, 3) == 0) ? rand64() : 64'd1000000 + 64'($urandom);
		step_max = (cap > 0 && cap < 40) ? 2 * int'(cap) : 80;
		dmax     = (stl > 1000) ? 1000 : int'(stl);
		enqueue(mk(CMD_ATTACH, 1'b1, 1'b1, wr, gen, now, now, 7'd0), 1'b0);
		for (int k = 1; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				if ($urandom_range(0, 1) == 0)
					gen = gen + 64'd1;
				wr = wr + 64'($urandom_range(0, 200));
				it = mk(CMD_ATTACH, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), wr,
					gen, rand64(), rand64(), 7'($urandom_range(0, 127)));
			end else if (r < 14) begin
				it = mk(CMD_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand64(),
					($urandom_range(0, 1) == 0) ? gen : rand64(), rand64(), rand64(),
					7'($urandom_range(0, 127)));
			end else begin
				wr = wr + 64'($urandom_range(0, step_max));
				if (r < 20)
					wr = wr + 64'(cap) + 64'($urandom_range(1, 100));
				else if (r < 24)
					gen = gen + 64'd1;
				else if (r < 27)
					gen = rand64();
				now   = now + 64'($urandom_range(1, 2000));
				delta = 64'($urandom_range(0, dmax));
				it = mk(CMD_READ, $urandom_range(0, 29) != 0, $urandom_range(0, 29) != 0, wr,
					gen, now - delta, now, 7'($urandom_range(1, 64)));
				q = $urandom_range(0, 39);
				if (q == 0)
					it.heartbeat_time = now - 64'(stl) - 64'($urandom_range(1, 50));
				else if (q == 1)
					it.heartbeat_time = '0;
				else if (q == 2)
					it.heartbeat_time = now + 64'($urandom_range(1, 50));
				else if (q < 7)
					it.now_time = '0;
				q = $urandom_range(0, 19);
				if (q == 0)
					it.req_frames = '0;
				else if (q == 1)
					it.req_frames = 7'($urandom_range(65, 127));
				else if (q == 2)
					it.req_frames = 7'd64;
			end
			enqueue(it, $urandom_range(0, 49) == 0);
		end
	endtask

	task automatic run_phase(logic [CAP_W-1:0] cap, logic [STALE_W-1:0] stl, logic pub,
			int n, bit calm);
		wait_idle();
		write_reg(CFG_RING_CAPACITY, {19'($urandom_range(0, 1) ? $urandom : 0), cap});
		write_reg(CFG_STALE_LIMIT, stl);
		write_reg(CFG_PUBLISH_ENABLE, {39'(rand64()), pub});
		n_settings++;
		quiet = calm;
		gen_phase(n, cap, stl);
	endtask

	initial begin
		m_cap   = RING_CAPACITY_RST;
		m_stale = STALE_LIMIT_RST;
		m_pub   = PUBLISH_ENABLE_RST;
		m_rd    = '0;
		m_gen   = '0;
		foreach (st_count[i])
			st_count[i] = 0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		directed();
		run_phase(21'd1, '1, 1'b1, 40, 1'b0);
		run_phase(21'd1048576, 40'd0, 1'b0, 40, 1'b0);
		run_phase(21'd0, 40'($urandom), 1'b1, 8, 1'b0);
		run_phase(21'd1048577, 40'($urandom), 1'b0, 10, 1'b0);
		run_phase(21'h1FFFFF, 40'($urandom), 1'b1, 8, 1'b1);
		run_phase(21'($urandom_range(2, 64)), 40'(rand64()), 1'b1, 40, 1'b0);
		run_phase(21'($urandom_range(1, 300)), 40'd1000, 1'($urandom_range(0, 1)), 40, 1'b1);
		run_phase(21'd16, 40'd5000, 1'b1, 40, 1'b0);
		run_phase(21'($urandom_range(1, 1048576)), 40'(rand64()), 1'b1, 40, 1'b0);
		run_phase(21'd4096, 40'd100000000, 1'b1, 40, 1'b0);

		wait_idle();
		repeat (150) @(posedge clk);
		while (frame_plan.size() != 0) begin
			want = frame_plan.pop_front();
			flag("missing frame", want, '0);
		end

		$display("%0d requests, %0d frame results over %0d register settings, %0d mismatches",
			n_items, n_results, n_settings, errors);
		$display("status mix: ok %0d unmapped %0d invalid %0d stale %0d gen %0d over %0d under %0d",
			st_count[0], st_count[1], st_count[2], st_count[3], st_count[4], st_count[5],
			st_count[6]);
		if (errors == 0) begin
			$display("PASS audio_ring_read_pointer_unit");
		end else begin
			$display("FAIL audio_ring_read_pointer_unit");
		end
		$finish;
	end

endmodule
